[sv/cfr_pkg.sv]
// Shared types and constants of the COBS frame receiver with CRC-8 check.
// No dependencies; every other file of the block refers to this package.
package cfr_pkg;

    typedef struct packed {
        logic       mode;
        logic [7:0] wire_byte;
    } item_t;

    typedef enum logic [3:0] {
        EV_NONE        = 4'd0,
        EV_DATA_BYTE   = 4'd1,
        EV_REQ_BYTE    = 4'd2,
        EV_DISC_BYTE   = 4'd3,
        EV_DATA_OK     = 4'd4,
        EV_REQ_OK      = 4'd5,
        EV_OTHER_OK    = 4'd6,
        EV_CRC_BAD     = 4'd7,
        EV_NEW         = 4'd8,
        EV_REPEAT      = 4'd9,
        EV_NOT_PENDING = 4'd10
    } event_t;

    typedef struct packed {
        event_t     event_res;
        logic [7:0] byte_value;
        logic [7:0] byte_index;
        logic [7:0] frame_length;
        logic       seq_no;
    } result_t;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_TYPE   = 3'd1,
        PH_LENGTH = 3'd2,
        PH_DATA   = 3'd3,
        PH_CRC    = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        TGT_NONE    = 2'd0,
        TGT_DATA    = 2'd1,
        TGT_REQUEST = 2'd2,
        TGT_DISCARD = 2'd3
    } target_t;

    typedef enum logic [1:0] {
        KIND_SERVICE = 2'd0,
        KIND_TYPE    = 2'd1,
        KIND_DATA    = 2'd2,
        KIND_CRC     = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        logic [7:0] index;
        logic [7:0] length;
        logic       crc_ok;
    } qitem_t;

    localparam logic [7:0] TYPE_DATA     = 8'h08;
    localparam logic [7:0] TYPE_REQ_EVEN = 8'h02;
    localparam logic [7:0] TYPE_REQ_ODD  = 8'h03;
    localparam logic [7:0] TYPE_SYNC     = 8'hFF;
    localparam logic [7:0] BLOCK_MAX     = 8'hFF;
    localparam logic [7:0] CRC_POLY      = 8'h07;
    localparam logic [1:0] SEQ_NONE      = 2'd2;

endpackage

[sv/cfr_front.sv]
// Front part of the frame receiver: COBS unstuffing, frame phase tracking and CRC-8.
// Depends on cfr_pkg; feeds classified requests into cfr_queue.
module cfr_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  cfr_pkg::item_t item,
    output logic           q_push,
    output cfr_pkg::qitem_t q_item
);

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] v;
        v = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            if (v[7])
                v = {v[6:0], 1'b0} ^ cfr_pkg::CRC_POLY;
            else
                v = {v[6:0], 1'b0};
        end
        return v;
    endfunction

    cfr_pkg::phase_t phase_reg, phase_next;
    logic [7:0] crc_reg, crc_next;
    logic [7:0] size_reg, size_next;
    logic [7:0] pos_reg, pos_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] count_reg, count_next;

    logic            byte_in;
    logic            raw_zero;
    logic            is_code;
    logic            drop;
    logic [7:0]      dbyte;
    logic [7:0]      count_inc;
    cfr_pkg::phase_t eff_phase;

    always_comb
    begin
        byte_in   = accept && !item.mode;
        raw_zero  = item.wire_byte == 8'd0;
        is_code   = !raw_zero && ({1'b0, pos_reg} + 9'd1 >= {1'b0, size_reg});
        drop      = is_code && (size_reg == cfr_pkg::BLOCK_MAX);
        dbyte     = is_code ? 8'd0 : item.wire_byte;
        eff_phase = raw_zero ? cfr_pkg::PH_START : phase_reg;
        count_inc = count_reg + 8'd1;
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (byte_in && !drop)
        begin
            unique case (eff_phase)
                cfr_pkg::PH_START:
                    phase_next = (dbyte == 8'd0) ? cfr_pkg::PH_TYPE : cfr_pkg::PH_START;
                cfr_pkg::PH_TYPE:
                    phase_next = cfr_pkg::PH_LENGTH;
                cfr_pkg::PH_LENGTH:
                    phase_next = (dbyte != 8'd0) ? cfr_pkg::PH_DATA : cfr_pkg::PH_CRC;
                cfr_pkg::PH_DATA:
                    phase_next = (count_inc >= length_reg) ? cfr_pkg::PH_CRC : cfr_pkg::PH_DATA;
                cfr_pkg::PH_CRC:
                    phase_next = cfr_pkg::PH_START;
                default:
                    phase_next = cfr_pkg::PH_START;
            endcase
        end
    end

    always_comb
    begin
        size_next   = size_reg;
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        length_next = length_reg;
        count_next  = count_reg;
        q_push      = 1'b0;
        q_item      = '{kind: cfr_pkg::KIND_SERVICE, value: dbyte, index: count_reg,
                        length: length_reg, crc_ok: dbyte == crc_reg};
        if (accept && item.mode)
        begin
            q_push = 1'b1;
        end
        else if (byte_in)
        begin
            if (!raw_zero)
            begin
                if (is_code)
                begin
                    size_next = item.wire_byte;
                    pos_next  = 8'd0;
                end
                else
                begin
                    pos_next = pos_reg + 8'd1;
                end
            end
            if (!drop)
            begin
                if (eff_phase != cfr_pkg::PH_CRC)
                    crc_next = crc8_step(crc_reg, dbyte);
                unique case (eff_phase)
                    cfr_pkg::PH_START:
                    begin
                        if (dbyte == 8'd0)
                        begin
                            crc_next  = 8'd0;
                            size_next = cfr_pkg::BLOCK_MAX;
                            pos_next  = cfr_pkg::BLOCK_MAX;
                        end
                    end
                    cfr_pkg::PH_TYPE:
                    begin
                        count_next  = 8'd0;
                        q_push      = 1'b1;
                        q_item.kind = cfr_pkg::KIND_TYPE;
                    end
                    cfr_pkg::PH_LENGTH:
                        length_next = dbyte;
                    cfr_pkg::PH_DATA:
                    begin
                        count_next  = count_inc;
                        q_push      = 1'b1;
                        q_item.kind = cfr_pkg::KIND_DATA;
                    end
                    cfr_pkg::PH_CRC:
                    begin
                        q_push      = 1'b1;
                        q_item.kind = cfr_pkg::KIND_CRC;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= cfr_pkg::PH_START;
            crc_reg    <= 8'd0;
            size_reg   <= cfr_pkg::BLOCK_MAX;
            pos_reg    <= cfr_pkg::BLOCK_MAX;
            length_reg <= 8'd0;
            count_reg  <= 8'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            crc_reg    <= crc_next;
            size_reg   <= size_next;
            pos_reg    <= pos_next;
            length_reg <= length_next;
            count_reg  <= count_next;
        end
    end

endmodule

[sv/cfr_queue.sv]
// Short register queue that parts the front and back of the frame receiver.
// Depends on cfr_pkg for the request type it stores.
module cfr_queue #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cfr_pkg::qitem_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output cfr_pkg::qitem_t head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cfr_pkg::qitem_t store_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    function automatic logic [AW-1:0] advance(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_comb
    begin
        full        = count_reg == CW'(DEPTH);
        empty       = count_reg == '0;
        head        = store_reg[rd_ptr_reg];
        wr_ptr_next = push ? advance(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? advance(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(DEPTH))
        else $error("queue count exceeds its depth");
    assert property (@(posedge clk) disable iff (!rst_n) !(push && full && !pop))
        else $error("request written into a full queue");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("request taken from an empty queue");
`endif

endmodule

[sv/cfr_back.sv]
// Back part of the frame receiver: payload targets, request holding and result register.
// Depends on cfr_pkg; takes classified requests from cfr_queue.
module cfr_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  cfr_pkg::qitem_t  q_head,
    output logic             q_pop,
    input  logic             pop,
    output logic             empty,
    output cfr_pkg::result_t result
);

    cfr_pkg::target_t target_reg, target_next;
    logic             pending_reg, pending_next;
    logic [7:0]       plen_reg, plen_next;
    logic             seq_reg, seq_next;
    logic [1:0]       las_reg, las_next;
    logic             out_valid_reg, out_valid_next;
    cfr_pkg::result_t out_reg, out_next;

    logic             res_valid;
    cfr_pkg::result_t res;

    always_comb
    begin
        q_pop        = !q_empty && (!out_valid_reg || pop);
        target_next  = target_reg;
        pending_next = pending_reg;
        plen_next    = plen_reg;
        seq_next     = seq_reg;
        las_next     = las_reg;
        res_valid    = 1'b1;
        res          = '{event_res: cfr_pkg::EV_NONE, byte_value: 8'd0, byte_index: 8'd0,
                         frame_length: 8'd0, seq_no: 1'b0};
        unique case (q_head.kind)
            cfr_pkg::KIND_SERVICE:
            begin
                if (!pending_reg)
                begin
                    res.event_res = cfr_pkg::EV_NOT_PENDING;
                end
                else
                begin
                    if (las_reg == cfr_pkg::SEQ_NONE || las_reg != {1'b0, seq_reg})
                    begin
                        res.event_res = cfr_pkg::EV_NEW;
                        las_next      = {1'b0, seq_reg};
                    end
                    else
                    begin
                        res.event_res = cfr_pkg::EV_REPEAT;
                    end
                    pending_next     = 1'b0;
                    res.frame_length = plen_reg;
                    res.seq_no       = seq_reg;
                end
            end
            cfr_pkg::KIND_TYPE:
            begin
                res_valid   = 1'b0;
                target_next = cfr_pkg::TGT_DISCARD;
                if (q_head.value == cfr_pkg::TYPE_DATA)
                begin
                    target_next = cfr_pkg::TGT_DATA;
                end
                else if (q_head.value == cfr_pkg::TYPE_REQ_EVEN
                         || q_head.value == cfr_pkg::TYPE_REQ_ODD)
                begin
                    if (!pending_reg)
                    begin
                        target_next = cfr_pkg::TGT_REQUEST;
                        seq_next    = q_head.value[0];
                    end
                end
                else if (q_head.value == cfr_pkg::TYPE_SYNC)
                begin
                    las_next = cfr_pkg::SEQ_NONE;
                end
            end
            cfr_pkg::KIND_DATA:
            begin
                res.byte_value = q_head.value;
                res.byte_index = q_head.index;
                case (target_reg)
                    cfr_pkg::TGT_DATA:    res.event_res = cfr_pkg::EV_DATA_BYTE;
                    cfr_pkg::TGT_REQUEST: res.event_res = cfr_pkg::EV_REQ_BYTE;
                    default:              res.event_res = cfr_pkg::EV_DISC_BYTE;
                endcase
            end
            cfr_pkg::KIND_CRC:
            begin
                res.frame_length = q_head.length;
                if (!q_head.crc_ok)
                begin
                    res.event_res = cfr_pkg::EV_CRC_BAD;
                end
                else if (target_reg == cfr_pkg::TGT_REQUEST)
                begin
                    res.event_res = cfr_pkg::EV_REQ_OK;
                    res.seq_no    = seq_reg;
                    pending_next  = 1'b1;
                    plen_next     = q_head.length;
                end
                else if (target_reg == cfr_pkg::TGT_DATA)
                begin
                    res.event_res = cfr_pkg::EV_DATA_OK;
                end
                else
                begin
                    res.event_res = cfr_pkg::EV_OTHER_OK;
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase

        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        if (q_pop && res_valid)
        begin
            out_next       = res;
            out_valid_next = 1'b1;
        end
        if (!q_pop)
        begin
            target_next  = target_reg;
            pending_next = pending_reg;
            plen_next    = plen_reg;
            seq_next     = seq_reg;
            las_next     = las_reg;
        end
        empty  = !out_valid_reg;
        result = out_reg;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= cfr_pkg::TGT_NONE;
            pending_reg   <= 1'b0;
            plen_reg      <= 8'd0;
            seq_reg       <= 1'b0;
            las_reg       <= cfr_pkg::SEQ_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            target_reg    <= target_next;
            pending_reg   <= pending_next;
            plen_reg      <= plen_next;
            seq_reg       <= seq_next;
            las_reg       <= las_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_head.kind == cfr_pkg::KIND_CRC && res.event_res == cfr_pkg::EV_REQ_OK)
        |=> pending_reg)
        else $error("good request frame did not leave a request held");
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_head.kind == cfr_pkg::KIND_SERVICE) |=> !pending_reg)
        else $error("serviced request is still held");
    assert property (@(posedge clk) disable iff (!rst_n) las_reg != 2'd3)
        else $error("last answered sequence holds an unused code");
`endif

endmodule

[sv/cobs_crc8_frame_receiver.sv]
// Top level of the COBS frame receiver with CRC-8 check.
// Depends on cfr_pkg and instantiates cfr_front, cfr_queue and cfr_back.
//
// Channel   Direction  Handshake       Payload
// item      in         push / full     cfr_pkg::item_t (mode, wire_byte)
// result    out        pop / empty     cfr_pkg::result_t (event, byte, index, length, seq)
//
// One item is accepted per cycle while full is low. The front is combinational and writes
// its request into the queue at the accepting edge; the back moves it from the queue into
// the result register once that register is empty or being popped. Reset clears the
// frame phase, CRC, COBS block counters, held request and all valid flags at once. A
// stalled result holds the back; the queue then takes QUEUE_DEPTH further requests before
// full rises, while start, length and dropped COBS code bytes need no entry.
module cobs_crc8_frame_receiver #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  cfr_pkg::item_t   item,
    output logic             empty,
    input  logic             pop,
    output cfr_pkg::result_t result
);

    logic            q_push;
    logic            q_pop;
    logic            q_empty;
    cfr_pkg::qitem_t q_in;
    cfr_pkg::qitem_t q_head;

    cfr_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (push && !full),
        .item   (item),
        .q_push (q_push),
        .q_item (q_in)
    );

    cfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .full      (full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    cfr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

[sim/cobs_crc8_frame_receiver_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for cobs_crc8_frame_receiver: COBS-coded frames, noise and
// service requests are pushed through the block and every result is checked against a
// local model of the deframer or a planned value. Depends on cfr_pkg and the block's RTL.
module cobs_crc8_frame_receiver_tb;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int ITEM_TARGET  = 1470;
    localparam int SETTLE_TICKS = 20;

    typedef enum int {
        DRAIN_FREE,
        DRAIN_COIN,
        DRAIN_PERIODIC,
        DRAIN_SLOW
    } drain_style_t;

    typedef struct packed {
        cfr_pkg::item_t   it;
        logic             fixed;
        cfr_pkg::result_t want;
        logic             hold;
    } plan_row_t;

    logic             clk   = 1'b0;
    logic             rst_n = 1'b0;
    logic             push  = 1'b0;
    logic             full;
    cfr_pkg::item_t   item  = '0;
    logic             empty;
    logic             pop   = 1'b0;
    cfr_pkg::result_t result;

    plan_row_t        wire_plan[$];
    cfr_pkg::result_t pending_results[$];
    int               accepted_n  = 0;
    int               cycle_count = 0;
    int               failures    = 0;

    drain_style_t drain_style = DRAIN_FREE;
    int           style_left  = 0;

    // Local copy of the deframer state.
    cfr_pkg::phase_t  rx_phase;
    logic [7:0]       crc_acc;
    logic [7:0]       block_size;
    logic [7:0]       block_pos;
    cfr_pkg::target_t target;
    logic [7:0]       payload_len;
    logic [7:0]       payload_cnt;
    logic             req_pending;
    logic [7:0]       held_len;
    logic             req_seq;
    logic [1:0]       answered_seq;

    cobs_crc8_frame_receiver dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .item  (item),
        .empty (empty),
        .pop   (pop),
        .result(result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] v;
        v = acc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            v = v[7] ? ({v[6:0], 1'b0} ^ cfr_pkg::CRC_POLY) : {v[6:0], 1'b0};
        end
        return v;
    endfunction

    function automatic bit step_receiver(input cfr_pkg::item_t it,
                                         output cfr_pkg::result_t r);
        logic [7:0] b;
        bit         short_block;
        r = '0;
        b = it.wire_byte;
        if (it.mode)
        begin
            if (!req_pending)
            begin
                r.event_res = cfr_pkg::EV_NOT_PENDING;
                return 1'b1;
            end
            if (answered_seq == cfr_pkg::SEQ_NONE || answered_seq != {1'b0, req_seq})
            begin
                r.event_res  = cfr_pkg::EV_NEW;
                answered_seq = {1'b0, req_seq};
            end
            else
            begin
                r.event_res = cfr_pkg::EV_REPEAT;
            end
            req_pending    = 1'b0;
            r.frame_length = held_len;
            r.seq_no       = req_seq;
            return 1'b1;
        end
        if (b != 8'h00)
        begin
            if (int'(block_pos) >= int'(block_size) - 1)
            begin
                short_block = block_size < cfr_pkg::BLOCK_MAX;
                block_size  = b;
                block_pos   = 8'h00;
                if (!short_block)
                    return 1'b0;
                b = 8'h00;
            end
            else
            begin
                block_pos = block_pos + 8'h01;
            end
        end
        else
        begin
            rx_phase = cfr_pkg::PH_START;
        end
        if (rx_phase != cfr_pkg::PH_CRC)
            crc_acc = crc8_next(crc_acc, b);
        case (rx_phase)
            cfr_pkg::PH_DATA:
            begin
                if (target == cfr_pkg::TGT_DATA)
                    r.event_res = cfr_pkg::EV_DATA_BYTE;
                else if (target == cfr_pkg::TGT_REQUEST)
                    r.event_res = cfr_pkg::EV_REQ_BYTE;
                else
                    r.event_res = cfr_pkg::EV_DISC_BYTE;
                r.byte_value = b;
                r.byte_index = payload_cnt;
                payload_cnt  = payload_cnt + 8'h01;
                if (payload_cnt >= payload_len)
                    rx_phase = cfr_pkg::PH_CRC;
                return 1'b1;
            end
            cfr_pkg::PH_START:
            begin
                if (b == 8'h00)
                begin
                    rx_phase   = cfr_pkg::PH_TYPE;
                    crc_acc    = 8'h00;
                    block_size = cfr_pkg::BLOCK_MAX;
                    block_pos  = cfr_pkg::BLOCK_MAX;
                end
                return 1'b0;
            end
            cfr_pkg::PH_TYPE:
            begin
                payload_cnt = 8'h00;
                target      = cfr_pkg::TGT_DISCARD;
                if (b == cfr_pkg::TYPE_DATA)
                begin
                    target = cfr_pkg::TGT_DATA;
                end
                else if (b == cfr_pkg::TYPE_REQ_EVEN || b == cfr_pkg::TYPE_REQ_ODD)
                begin
                    if (!req_pending)
                    begin
                        target  = cfr_pkg::TGT_REQUEST;
                        req_seq = b[0];
                    end
                end
                else if (b == cfr_pkg::TYPE_SYNC)
                begin
                    answered_seq = cfr_pkg::SEQ_NONE;
                end
                rx_phase = cfr_pkg::PH_LENGTH;
                return 1'b0;
            end
            cfr_pkg::PH_LENGTH:
            begin
                payload_len = b;
                if (b != 8'h00)
                    rx_phase = cfr_pkg::PH_DATA;
                else
                    rx_phase = cfr_pkg::PH_CRC;
                return 1'b0;
            end
            cfr_pkg::PH_CRC:
            begin
                rx_phase       = cfr_pkg::PH_START;
                r.frame_length = payload_len;
                if (b != crc_acc)
                begin
                    r.event_res = cfr_pkg::EV_CRC_BAD;
                end
                else if (target == cfr_pkg::TGT_REQUEST)
                begin
                    held_len    = payload_len;
                    req_pending = 1'b1;
                    r.event_res = cfr_pkg::EV_REQ_OK;
                    r.seq_no    = req_seq;
                end
                else if (target == cfr_pkg::TGT_DATA)
                begin
                    r.event_res = cfr_pkg::EV_DATA_OK;
                end
                else
                begin
                    r.event_res = cfr_pkg::EV_OTHER_OK;
                end
                return 1'b1;
            end
            default:
            begin
                rx_phase = cfr_pkg::PH_START;
                return 1'b0;
            end
        endcase
    endfunction

    task automatic add_row(input logic mode, input logic [7:0] b, input logic fixed,
                           input cfr_pkg::result_t want);
        plan_row_t row;
        row              = '0;
        row.it.mode      = mode;
        row.it.wire_byte = b;
        row.fixed        = fixed;
        row.want         = want;
        wire_plan.push_back(row);
    endtask

    // A fill of -1 gives random bytes rich in zeros, -2 gives random non-zero bytes
    // (long runs reach full-size blocks), and any other value is used as every byte.
    task automatic append_frame(input logic [7:0] ftype, input int len, input int fill,
                                input bit corrupt, input bit cut);
        logic [7:0] frame_bytes[$];
        logic [7:0] coded[$];
        logic [7:0] acc;
        int         code_at;
        int         keep;
        frame_bytes.push_back(ftype);
        frame_bytes.push_back(8'(len));
        repeat (len)
        begin
            if (fill == -1)
                frame_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
            else if (fill == -2)
                frame_bytes.push_back(8'($urandom_range(1, 255)));
            else
                frame_bytes.push_back(8'(fill));
        end
        acc = 8'h00;
        foreach (frame_bytes[i])
            acc = crc8_next(acc, frame_bytes[i]);
        if (corrupt)
            acc = acc ^ 8'($urandom_range(1, 255));
        frame_bytes.push_back(acc);
        code_at = 0;
        coded.push_back(8'h00);
        foreach (frame_bytes[i])
        begin
            if (frame_bytes[i] == 8'h00)
            begin
                coded[code_at] = 8'(coded.size() - code_at);
                code_at = coded.size();
                coded.push_back(8'h00);
            end
            else
            begin
                coded.push_back(frame_bytes[i]);
                if (coded.size() - code_at == 255)
                begin
                    coded[code_at] = cfr_pkg::BLOCK_MAX;
                    code_at = coded.size();
                    coded.push_back(8'h00);
                end
            end
        end
        coded[code_at] = 8'(coded.size() - code_at);
        keep = cut ? $urandom_range(1, coded.size() - 1) : coded.size();
        add_row(1'b0, 8'h00, 1'b0, '0);
        for (int i = 0; i < keep; i++)
            add_row(1'b0, coded[i], 1'b0, '0);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (style_left == 0)
            begin
                drain_style <= drain_style_t'($urandom_range(0, 3));
                style_left  <= $urandom_range(20, 250);
            end
            else
            begin
                style_left <= style_left - 1;
            end
            case (drain_style)
                DRAIN_FREE:     pop <= 1'b1;
                DRAIN_COIN:     pop <= 1'($urandom_range(0, 1));
                DRAIN_PERIODIC: pop <= (style_left % 4) != 3;
                default:        pop <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cfr_pkg::result_t predicted;
        cfr_pkg::result_t want;
        bit               produces;
        if (rst_n)
        begin
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
            else
            begin
                if (pop && !empty)
                begin
                    if (pending_results.size() == 0)
                    begin
                        $error("result with no request waiting: event_res %0d",
                               result.event_res);
                        failures++;
                    end
                    else
                    begin
                        want = pending_results.pop_front();
                        if (result.event_res !== want.event_res)
                        begin
                            $error("event_res: expected %0d, got %0d",
                                   want.event_res, result.event_res);
                            failures++;
                        end
                        if (result.byte_value !== want.byte_value)
                        begin
                            $error("byte_value: expected %0d, got %0d",
                                   want.byte_value, result.byte_value);
                            failures++;
                        end
                        if (result.byte_index !== want.byte_index)
                        begin
                            $error("byte_index: expected %0d, got %0d",
                                   want.byte_index, result.byte_index);
                            failures++;
                        end
                        if (result.frame_length !== want.frame_length)
                        begin
                            $error("frame_length: expected %0d, got %0d",
                                   want.frame_length, result.frame_length);
                            failures++;
                        end
                        if (result.seq_no !== want.seq_no)
                        begin
                            $error("seq_no: expected %0d, got %0d",
                                   want.seq_no, result.seq_no);
                            failures++;
                        end
                    end
                end
                if (push && !full)
                begin
                    produces = step_receiver(item, predicted);
                    if (wire_plan[accepted_n].fixed)
                        pending_results.push_back(wire_plan[accepted_n].want);
                    else if (produces)
                        pending_results.push_back(predicted);
                    accepted_n++;
                end
            end
        end
    end

    initial
    begin
        cfr_pkg::result_t want;
        int               directed_rows;
        int               pick;
        int               len;
        logic [7:0]       ftype;
        int               burst_left;
        int               gap;

        rx_phase     = cfr_pkg::PH_START;
        crc_acc      = 8'h00;
        block_size   = cfr_pkg::BLOCK_MAX;
        block_pos    = cfr_pkg::BLOCK_MAX;
        target       = cfr_pkg::TGT_NONE;
        payload_len  = 8'h00;
        payload_cnt  = 8'h00;
        req_pending  = 1'b0;
        held_len     = 8'h00;
        req_seq      = 1'b0;
        answered_seq = cfr_pkg::SEQ_NONE;

        // Directed part: service with nothing held, a decoded zero starting a frame,
        // a data frame, an empty request, a request ignored while one is held, then
        // service of the held request and a sync frame with a broken check byte.
        want = '0;
        want.event_res = cfr_pkg::EV_NOT_PENDING;
        add_row(1'b1, 8'hA5, 1'b1, want);
        add_row(1'b0, 8'h01, 1'b0, '0);
        add_row(1'b0, 8'h01, 1'b0, '0);
        append_frame(cfr_pkg::TYPE_DATA, 1, 8'h00, 1'b0, 1'b0);
        append_frame(cfr_pkg::TYPE_REQ_ODD, 0, 0, 1'b0, 1'b0);
        append_frame(cfr_pkg::TYPE_REQ_EVEN, 1, 8'hFF, 1'b0, 1'b0);
        want = '0;
        want.event_res = cfr_pkg::EV_NEW;
        want.seq_no    = 1'b1;
        add_row(1'b1, 8'h5A, 1'b1, want);
        append_frame(cfr_pkg::TYPE_SYNC, 0, 0, 1'b1, 1'b0);
        directed_rows = wire_plan.size();

        while (wire_plan.size() < directed_rows + ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
            begin
                add_row(1'b1, 8'($urandom), 1'b0, '0);
            end
            else if (pick < 18)
            begin
                repeat ($urandom_range(1, 6))
                    add_row(1'b0, ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom),
                            1'b0, '0);
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: ftype = cfr_pkg::TYPE_DATA;
                    4, 5:       ftype = cfr_pkg::TYPE_REQ_EVEN;
                    6:          ftype = cfr_pkg::TYPE_REQ_ODD;
                    7:          ftype = cfr_pkg::TYPE_SYNC;
                    default:    ftype = 8'($urandom);
                endcase
                if ($urandom_range(0, 49) == 0)
                begin
                    len = ($urandom_range(0, 1) == 0) ? 255 : $urandom_range(100, 254);
                    append_frame(ftype, len, -2, $urandom_range(0, 9) == 0, 1'b0);
                end
                else
                begin
                    len = $urandom_range(0, 12);
                    append_frame(ftype, len, -1, $urandom_range(0, 7) == 0,
                                 $urandom_range(0, 14) == 0);
                end
            end
        end
        wire_plan[directed_rows].hold = 1'b1;
        wire_plan[wire_plan.size() / 2].hold = 1'b1;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        burst_left = 0;
        for (int n = 0; n < wire_plan.size(); n++)
        begin
            gap = 0;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                if ($urandom_range(0, 3) != 0)
                    gap = $urandom_range(1, 12);
            end
            burst_left--;
            if (gap > 0 || wire_plan[n].hold)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
                if (wire_plan[n].hold)
                begin
                    @(negedge clk);
                    while (pending_results.size() != 0)
                        @(negedge clk);
                    @(posedge clk);
                end
            end
            push <= 1'b1;
            item <= wire_plan[n].it;
            do
                @(posedge clk);
            while (full);
        end
        push <= 1'b0;

        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
        if (failures == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[filelist.f]
sv/cfr_pkg.sv
sv/cfr_front.sv
sv/cfr_queue.sv
sv/cfr_back.sv
sv/cobs_crc8_frame_receiver.sv
sim/cobs_crc8_frame_receiver_tb.sv
